>>> rtl/etb_pkg.sv
// Shared types and constants of the elimination tree builder.
// Used by etb_ctrl, etb_datapath and elimination_tree_builder; no dependencies.
package etb_pkg;

  localparam int NODES   = 1024;
  localparam int NODE_W  = $clog2(NODES);
  localparam int LINK_W  = NODE_W + 1;
  localparam int TDATA_W = ((2 * NODE_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_EMIT
  } etb_state_t;

  typedef struct packed {
    logic clr_en;
    logic load_item;
    logic rd_en;
    logic rd_sel_next;
    logic wr_en;
    logic step;
    logic out_load;
  } etb_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic walk_needed;
    logic link_valid;
    logic link_below;
    logic out_free;
  } etb_sts_t;

endpackage

>>> rtl/etb_ctrl.sv
// Controller state machine of the elimination tree builder.
// Depends on etb_pkg; drives etb_datapath through etb_cmd_t.
module etb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  etb_pkg::etb_sts_t sts,
  output etb_pkg::etb_cmd_t cmd
);

  etb_pkg::etb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etb_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      etb_pkg::S_CLEAR: begin
        if (sts.clr_done) state_next = etb_pkg::S_IDLE;
      end
      etb_pkg::S_IDLE: begin
        if (s_tvalid && sts.walk_needed) state_next = etb_pkg::S_READ;
      end
      etb_pkg::S_READ: begin
        state_next = etb_pkg::S_CHECK;
      end
      etb_pkg::S_CHECK: begin
        if (!sts.link_valid) begin
          state_next = sts.out_free ? etb_pkg::S_IDLE : etb_pkg::S_EMIT;
        end else if (!sts.link_below) begin
          state_next = etb_pkg::S_IDLE;
        end
      end
      etb_pkg::S_EMIT: begin
        if (sts.out_free) state_next = etb_pkg::S_IDLE;
      end
      default: state_next = etb_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      etb_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      etb_pkg::S_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      etb_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
      end
      etb_pkg::S_CHECK: begin
        cmd.wr_en = 1'b1;
        if (!sts.link_valid) begin
          cmd.out_load = sts.out_free;
        end else if (sts.link_below) begin
          cmd.rd_en       = 1'b1;
          cmd.rd_sel_next = 1'b1;
          cmd.step        = 1'b1;
        end
      end
      etb_pkg::S_EMIT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    state == etb_pkg::S_CHECK |->
      $past(state) == etb_pkg::S_READ || $past(state) == etb_pkg::S_CHECK)
    else $error("check state entered without a read");

  a_walk_starts: assert property (@(posedge clk) disable iff (rst)
    (state == etb_pkg::S_IDLE && s_tvalid && s_tready && sts.walk_needed)
      |=> state == etb_pkg::S_READ)
    else $error("accepted entry above diagonal did not start a walk");

  a_clear_holds_input: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_en |-> !s_tready && !cmd.wr_en)
    else $error("request or link write during clearing pass");

endmodule

>>> rtl/etb_datapath.sv
// Datapath of the elimination tree builder: ancestor link memory, walk registers
// and output register. Depends on etb_pkg; commanded by etb_ctrl.
module etb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  etb_pkg::etb_cmd_t             cmd,
  output etb_pkg::etb_sts_t             sts,
  input  logic [etb_pkg::TDATA_W-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [etb_pkg::TDATA_W-1:0]   m_tdata
);

  logic [etb_pkg::LINK_W-1:0] mem [etb_pkg::NODES];
  logic [etb_pkg::LINK_W-1:0] rd_data;
  logic [etb_pkg::NODE_W-1:0] rd_node;
  logic [etb_pkg::NODE_W-1:0] rd_addr;
  logic [etb_pkg::NODE_W-1:0] clr_cnt;
  logic [etb_pkg::NODE_W-1:0] cur;
  logic [etb_pkg::NODE_W-1:0] k;
  logic [etb_pkg::NODE_W-1:0] row;
  logic [etb_pkg::NODE_W-1:0] col;
  logic [etb_pkg::NODE_W-1:0] out_child;
  logic [etb_pkg::NODE_W-1:0] out_parent;

  assign row     = s_tdata[etb_pkg::NODE_W-1:0];
  assign col     = s_tdata[2*etb_pkg::NODE_W-1:etb_pkg::NODE_W];
  assign rd_node = rd_data[etb_pkg::NODE_W-1:0];
  assign rd_addr = cmd.rd_sel_next ? rd_node : cur;

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.wr_en) begin
      mem[cur] <= {1'b1, k};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur <= row;
      k   <= col;
    end else if (cmd.step) begin
      cur <= rd_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_child  <= cur;
      out_parent <= k;
    end
  end

  assign m_tdata = {{(etb_pkg::TDATA_W - 2 * etb_pkg::NODE_W){1'b0}}, out_parent, out_child};

  always_comb begin
    sts.clr_done    = cmd.clr_en && (clr_cnt == etb_pkg::NODE_W'(etb_pkg::NODES - 1));
    sts.walk_needed = row < col;
    sts.link_valid  = rd_data[etb_pkg::NODE_W];
    sts.link_below  = rd_node < k;
    sts.out_free    = !m_tvalid || m_tready;
  end

  a_chain_rises: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> rd_node > cur)
    else $error("ancestor link does not point upwards");

  a_result_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_parent > out_child)
    else $error("emitted parent not above child");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !m_tvalid || m_tready)
    else $error("pending result overwritten");

endmodule

>>> rtl/elimination_tree_builder.sv
// Elimination tree builder, top level: joins etb_ctrl and etb_datapath.
// Depends on etb_pkg, etb_ctrl and etb_datapath.
//
// Takes nonzero positions (row, column) of a sparse symmetric matrix in
// nondecreasing column order and emits one (child, parent) pair each time a
// walk up the path-compressed ancestor links reaches a root. After reset a
// clearing pass sweeps the 1024-entry link memory, one entry a cycle, with
// s_tready low. An entry on or below the diagonal is taken without a walk.
// An entry above it starts a walk: S_READ does a registered read of the link
// memory, which has one read and one write port, then S_CHECK writes back each
// visited link and reads the next link it points to. A result held
// in the output register does not stop the next request from being taken, but
// a walk that reaches a root while that result is still held waits until the
// output register drains before it ends.
module elimination_tree_builder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [etb_pkg::TDATA_W-1:0] s_tdata,  // row_index, col_index, zero pad
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [etb_pkg::TDATA_W-1:0] m_tdata   // child_node, parent_node, zero pad
);

  etb_pkg::etb_cmd_t cmd;
  etb_pkg::etb_sts_t sts;

  etb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  etb_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> dv/elimination_tree_builder_test.sv
`timescale 1ns / 1ps
// Testbench for elimination_tree_builder: a directed table, then a column sweep, each request
// scored against a local model of the ancestor links or a fixed table entry. Depends on etb_pkg and the RTL.
module elimination_tree_builder_test;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 1100;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_DIRECTED   = 24;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_EMITS,
    ROW_SILENT
  } stim_kind_t;

  typedef struct packed {
    logic [etb_pkg::NODE_W-1:0] row;
    logic [etb_pkg::NODE_W-1:0] col;
    stim_kind_t                 kind;
    logic [etb_pkg::NODE_W-1:0] child;
    logic [etb_pkg::NODE_W-1:0] parent;
  } dir_row_t;

  typedef struct packed {
    logic [etb_pkg::NODE_W-1:0] child;
    logic [etb_pkg::NODE_W-1:0] parent;
  } parent_pair_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [etb_pkg::TDATA_W-1:0] s_tdata;   // row_index, col_index, zero pad
  logic                        m_tvalid;
  logic                        m_tready;
  logic [etb_pkg::TDATA_W-1:0] m_tdata;   // child_node, parent_node, zero pad

  bit                         link_set [etb_pkg::NODES];
  logic [etb_pkg::NODE_W-1:0] link_to  [etb_pkg::NODES];
  parent_pair_t               pending_edges [$];
  int                         error_count;
  int                         idle_cycles;
  int                         send_idle_pct;
  int                         recv_stall_pct;
  int                         hold_left;

  dir_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{10'd0,    10'd1,    ROW_EMITS,   10'd0,    10'd1},
    '{10'd0,    10'd0,    ROW_SILENT,  10'd0,    10'd0},
    '{10'd1023, 10'd1023, ROW_SILENT,  10'd0,    10'd0},
    '{10'd1023, 10'd0,    ROW_SILENT,  10'd0,    10'd0},
    '{10'd1022, 10'd1023, ROW_EMITS,   10'd1022, 10'd1023},
    '{10'd5,    10'd5,    ROW_SILENT,  10'd0,    10'd0},
    '{10'd0,    10'd2,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd1,    10'd2,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd2,    10'd3,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd0,    10'd4,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd3,    10'd4,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd1,    10'd5,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd4,    10'd5,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd0,    10'd1,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd6,    10'd7,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd0,    10'd8,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd7,    10'd8,    ROW_PREDICT, 10'd0,    10'd0},
    '{10'd341,  10'd682,  ROW_PREDICT, 10'd0,    10'd0},
    '{10'd682,  10'd1021, ROW_PREDICT, 10'd0,    10'd0},
    '{10'd0,    10'd1021, ROW_PREDICT, 10'd0,    10'd0},
    '{10'd512,  10'd1022, ROW_PREDICT, 10'd0,    10'd0},
    '{10'd1021, 10'd1022, ROW_PREDICT, 10'd0,    10'd0},
    '{10'd10,   10'd9,    ROW_SILENT,  10'd0,    10'd0},
    '{10'd1021, 10'd1023, ROW_PREDICT, 10'd0,    10'd0}
  };

  elimination_tree_builder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // walk up from row towards col, compressing links; true when a root is found
  function automatic bit climb_links(input logic [etb_pkg::NODE_W-1:0] row,
                                     input logic [etb_pkg::NODE_W-1:0] col,
                                     output logic [etb_pkg::NODE_W-1:0] root);
    int unsigned cur;
    int unsigned nxt;
    int unsigned steps;
    bit          had;
    root = '0;
    if (row >= col) return 1'b0;
    cur   = 32'(row);
    steps = 0;
    while (cur < 32'(col) && steps <= etb_pkg::NODES) begin
      had           = link_set[cur];
      nxt           = 32'(link_to[cur]);
      link_set[cur] = 1'b1;
      link_to[cur]  = col;
      steps++;
      if (!had) begin
        root = cur[etb_pkg::NODE_W-1:0];
        return 1'b1;
      end
      cur = nxt;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic queue_edge(input logic [etb_pkg::NODE_W-1:0] child,
                            input logic [etb_pkg::NODE_W-1:0] parent);
    parent_pair_t edge_pair;
    edge_pair.child  = child;
    edge_pair.parent = parent;
    pending_edges.insert(pending_edges.size(), edge_pair);
  endtask

  // present one request, wait for its acceptance, then advance the model
  task automatic drive_request(input logic [etb_pkg::NODE_W-1:0] row,
                               input logic [etb_pkg::NODE_W-1:0] col,
                               output bit hit, output logic [etb_pkg::NODE_W-1:0] root);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(etb_pkg::TDATA_W - 2 * etb_pkg::NODE_W){1'b0}}, col, row};
    do @(posedge clk); while (!s_tready);
    hit = climb_links(row, col, root);
  endtask

  task automatic issue_entry(input logic [etb_pkg::NODE_W-1:0] row,
                             input logic [etb_pkg::NODE_W-1:0] col);
    bit                         hit;
    logic [etb_pkg::NODE_W-1:0] root;
    drive_request(row, col, hit, root);
    if (hit) queue_edge(root, col);
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    parent_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_edges.size() == 0) begin
        report_mismatch("unexpected result, child", int'(m_tdata[etb_pkg::NODE_W-1:0]), -1);
      end else begin
        want = pending_edges.pop_front();
        if (m_tdata[etb_pkg::NODE_W-1:0] !== want.child)
          report_mismatch("child_node", int'(m_tdata[etb_pkg::NODE_W-1:0]),
                          int'(want.child));
        if (m_tdata[2*etb_pkg::NODE_W-1:etb_pkg::NODE_W] !== want.parent)
          report_mismatch("parent_node", int'(m_tdata[2*etb_pkg::NODE_W-1:etb_pkg::NODE_W]),
                          int'(want.parent));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit                         hit;
    logic [etb_pkg::NODE_W-1:0] root;
    int                         n;
    logic [etb_pkg::NODE_W-1:0] row;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    rst            = 1'b1;
    error_count    = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    for (int i = 0; i < etb_pkg::NODES; i++) begin
      link_set[i] = 1'b0;
      link_to[i]  = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      drive_request(directed_rows[i].row, directed_rows[i].col, hit, root);
      case (directed_rows[i].kind)
        ROW_EMITS: begin
          queue_edge(directed_rows[i].child, directed_rows[i].parent);
        end
        ROW_PREDICT: begin
          if (hit) queue_edge(root, directed_rows[i].col);
        end
        default: ;
      endcase
    end

    // sweep columns upwards; mostly ordered entries, some lower-triangle and out-of-order noise
    for (int k = 1; k < etb_pkg::NODES; k++) begin
      case (k)
        64:  hold_left = HOLD_CYCLES;
        256: begin
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
        512: begin
          send_idle_pct  = 0;
          recv_stall_pct = 61;
        end
        768: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
        default: ;
      endcase
      n = int'($urandom_range(0, 2)) + int'($urandom_range(0, 9) == 0);
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 3) == 0) row = etb_pkg::NODE_W'($urandom_range(0, k - 1));
        else row = etb_pkg::NODE_W'($urandom_range((k > 8) ? k - 8 : 0, k - 1));
        issue_entry(row, etb_pkg::NODE_W'(k));
      end
      if ($urandom_range(0, 9) == 0)
        issue_entry(etb_pkg::NODE_W'($urandom_range(k, etb_pkg::NODES - 1)),
                    etb_pkg::NODE_W'(k));
      if ($urandom_range(0, 19) == 0)
        issue_entry(etb_pkg::NODE_W'($urandom_range(0, etb_pkg::NODES - 1)),
                    etb_pkg::NODE_W'($urandom_range(0, etb_pkg::NODES - 1)));
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
